FILE: sv/pll_pkg.sv
package pll_pkg;

	localparam int MODE_W   = 1;
	localparam int POS_W    = 4;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 1'b0,
		MODE_DELETE = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_BAD_POS = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FREE_WAIT,
		ST_WALK_RD,
		ST_WALK_NX,
		ST_INS_LINK,
		ST_INS_SPLICE,
		ST_DEL_RD,
		ST_DEL_NX,
		ST_DEL_SPLICE,
		ST_DEL_FREE,
		ST_DONE
	} state_t;

endpackage

FILE: sv/pll_req_if.sv
interface pll_req_if;
	logic                              valid;
	logic                              ready;
	logic [pll_pkg::MODE_W-1:0]        mode;
	logic [pll_pkg::POS_W-1:0]         position;
	logic signed [pll_pkg::DATA_W-1:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink (input valid, input mode, input position, input value, output ready);
endinterface

FILE: sv/pll_rsp_if.sv
interface pll_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [pll_pkg::STATUS_W-1:0]      status;
	logic signed [pll_pkg::DATA_W-1:0] removed_value;
	logic [pll_pkg::COUNT_W-1:0]       item_count;

	modport source (output valid, output status, output removed_value, output item_count,
		input ready);
	modport sink (input valid, input status, input removed_value, input item_count,
		output ready);
endinterface

FILE: sv/pll_link_mem.sv
module pll_link_mem #(
	parameter int CAPACITY = 8,
	parameter int AW       = 3,
	parameter int LW       = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] raddr,
	output logic [LW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [LW-1:0] wdata
);

	logic [LW-1:0]       mem [CAPACITY];
	logic [CAPACITY-1:0] written_q;
	logic [LW-1:0]       rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// unwritten slot reads as its reset link: the following slot
	always_ff @(posedge clk) begin
		if (written_q[raddr]) begin
			rdata_q <= mem[raddr];
		end else begin
			rdata_q <= LW'(raddr) + LW'(1);
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/pll_value_mem.sv
module pll_value_mem #(
	parameter int CAPACITY = 8,
	parameter int AW       = 3
) (
	input  logic                              clk,
	input  logic [AW-1:0]                     raddr,
	output logic signed [pll_pkg::DATA_W-1:0] rdata,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [pll_pkg::DATA_W-1:0] wdata
);

	logic signed [pll_pkg::DATA_W-1:0] mem [CAPACITY];
	logic signed [pll_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/positional_linked_list.sv
// channel  dir  handshake     payload
// req      in   valid/ready   mode, position, value
// rsp      out  valid/ready   status, removed_value, item_count
//
// One item at a time: req.ready is high only while idle, so a new item is not accepted until
// the result of the last one has been taken. Each step of the walk is a read of the link
// memory followed by a state that follows the link just read.
// Reset empties the list and chains all slots on the free list at once.
// The result waits in the output register until taken; req.ready stays low meanwhile.
module positional_linked_list #(
	parameter int CAPACITY = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	pll_req_if.sink   req,
	pll_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > pll_pkg::POS_W) ? CW : pll_pkg::POS_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

	pll_pkg::state_t state_q, state_d;

	logic [LW-1:0] head_q, free_q;
	logic [CW-1:0] count_q;

	pll_pkg::mode_t                    mode_q;
	logic [pll_pkg::POS_W-1:0]         pos_q, step_q;
	logic signed [pll_pkg::DATA_W-1:0] value_q, removed_q;
	logic [LW-1:0]                     prev_q, nxt_q, fn_q, vnext_q;
	pll_pkg::status_t                  status_q;

	logic [AW-1:0] link_raddr, link_waddr, val_raddr;
	logic [LW-1:0] link_rdata, link_wdata, walk_n;
	logic          link_we, val_we;
	logic signed [pll_pkg::DATA_W-1:0] val_rdata;
	logic [MW-1:0] pos_ext, cnt_ext;
	logic          table_full;

	function automatic logic [LW-1:0] clean(input logic [LW-1:0] l);
		return (l < NULL_LINK) ? l : NULL_LINK;
	endfunction

	assign pos_ext    = MW'(pos_q);
	assign cnt_ext    = MW'(count_q);
	assign table_full = (free_q >= NULL_LINK) || (count_q >= CW'(CAPACITY));
	assign walk_n     = (prev_q == NULL_LINK) ? clean(head_q) : clean(link_rdata);

	pll_link_mem #(.CAPACITY(CAPACITY), .AW(AW), .LW(LW)) u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (link_raddr),
		.rdata  (link_rdata),
		.we     (link_we),
		.waddr  (link_waddr),
		.wdata  (link_wdata)
	);

	pll_value_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_value (
		.clk   (clk),
		.raddr (val_raddr),
		.rdata (val_rdata),
		.we    (val_we),
		.waddr (free_q[AW-1:0]),
		.wdata (value_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pll_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		link_raddr = prev_q[AW-1:0];
		link_waddr = prev_q[AW-1:0];
		link_wdata = nxt_q;
		link_we    = 1'b0;
		val_raddr  = nxt_q[AW-1:0];
		val_we     = 1'b0;
		unique case (state_q)
			pll_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = pll_pkg::ST_CHECK;
				end
			end
			pll_pkg::ST_CHECK: begin
				link_raddr = free_q[AW-1:0];
				if (mode_q == pll_pkg::MODE_INSERT) begin
					if (table_full || pos_ext > cnt_ext) begin
						state_d = pll_pkg::ST_DONE;
					end else begin
						state_d = pll_pkg::ST_FREE_WAIT;
					end
				end else if (pos_ext >= cnt_ext) begin
					state_d = pll_pkg::ST_DONE;
				end else begin
					state_d = pll_pkg::ST_WALK_RD;
				end
			end
			pll_pkg::ST_FREE_WAIT: state_d = pll_pkg::ST_WALK_RD;
			pll_pkg::ST_WALK_RD:   state_d = pll_pkg::ST_WALK_NX;
			pll_pkg::ST_WALK_NX: begin
				if (step_q == pos_q || walk_n == NULL_LINK) begin
					if (mode_q == pll_pkg::MODE_INSERT) begin
						state_d = pll_pkg::ST_INS_LINK;
					end else if (walk_n == NULL_LINK) begin
						state_d = pll_pkg::ST_DONE;
					end else begin
						state_d = pll_pkg::ST_DEL_RD;
					end
				end else begin
					state_d = pll_pkg::ST_WALK_RD;
				end
			end
			pll_pkg::ST_INS_LINK: begin
				link_we    = 1'b1;
				link_waddr = free_q[AW-1:0];
				link_wdata = nxt_q;
				val_we     = 1'b1;
				state_d    = pll_pkg::ST_INS_SPLICE;
			end
			pll_pkg::ST_INS_SPLICE: begin
				link_we    = (prev_q != NULL_LINK);
				link_wdata = free_q;
				state_d    = pll_pkg::ST_DONE;
			end
			pll_pkg::ST_DEL_RD: begin
				link_raddr = nxt_q[AW-1:0];
				state_d    = pll_pkg::ST_DEL_NX;
			end
			pll_pkg::ST_DEL_NX: state_d = pll_pkg::ST_DEL_SPLICE;
			pll_pkg::ST_DEL_SPLICE: begin
				link_we    = (prev_q != NULL_LINK);
				link_wdata = vnext_q;
				state_d    = pll_pkg::ST_DEL_FREE;
			end
			pll_pkg::ST_DEL_FREE: begin
				link_we    = 1'b1;
				link_waddr = nxt_q[AW-1:0];
				link_wdata = free_q;
				state_d    = pll_pkg::ST_DONE;
			end
			pll_pkg::ST_DONE: begin
				if (rsp.ready) begin
					state_d = pll_pkg::ST_IDLE;
				end
			end
			default: state_d = pll_pkg::ST_IDLE;
		endcase
	end

	// list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NULL_LINK;
			free_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				pll_pkg::ST_INS_SPLICE: begin
					if (prev_q == NULL_LINK) begin
						head_q <= free_q;
					end
					free_q  <= fn_q;
					count_q <= count_q + CW'(1);
				end
				pll_pkg::ST_DEL_SPLICE: begin
					if (prev_q == NULL_LINK) begin
						head_q <= vnext_q;
					end
				end
				pll_pkg::ST_DEL_FREE: begin
					free_q  <= nxt_q;
					count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pll_pkg::ST_IDLE: begin
				mode_q    <= pll_pkg::mode_t'(req.mode);
				pos_q     <= req.position;
				value_q   <= req.value;
				prev_q    <= NULL_LINK;
				step_q    <= '0;
				status_q  <= pll_pkg::STATUS_OK;
				removed_q <= '0;
			end
			pll_pkg::ST_CHECK: begin
				if (mode_q == pll_pkg::MODE_INSERT && table_full) begin
					status_q <= pll_pkg::STATUS_FULL;
				end else if (mode_q == pll_pkg::MODE_INSERT && pos_ext > cnt_ext) begin
					status_q <= pll_pkg::STATUS_BAD_POS;
				end else if (mode_q == pll_pkg::MODE_DELETE && pos_ext >= cnt_ext) begin
					status_q <= pll_pkg::STATUS_BAD_POS;
				end
			end
			pll_pkg::ST_FREE_WAIT: fn_q <= clean(link_rdata);
			pll_pkg::ST_WALK_NX: begin
				if (step_q == pos_q || walk_n == NULL_LINK) begin
					nxt_q <= walk_n;
					if (mode_q == pll_pkg::MODE_DELETE && walk_n == NULL_LINK) begin
						status_q <= pll_pkg::STATUS_BAD_POS;
					end
				end else begin
					prev_q <= walk_n;
					step_q <= step_q + pll_pkg::POS_W'(1);
				end
			end
			pll_pkg::ST_DEL_NX: begin
				vnext_q   <= clean(link_rdata);
				removed_q <= val_rdata;
			end
			default: begin
			end
		endcase
	end

	assign req.ready         = (state_q == pll_pkg::ST_IDLE);
	assign rsp.valid         = (state_q == pll_pkg::ST_DONE);
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.item_count    = pll_pkg::COUNT_W'(count_q);

endmodule

FILE: sim/tb_positional_linked_list.sv
module tb_positional_linked_list;

	localparam int LIST_CAP  = 8;
	localparam int SLOT_W    = $clog2(LIST_CAP);
	localparam int NULL_SLOT = LIST_CAP;
	localparam int HOLD_LEN  = 80;

	typedef struct {
		pll_pkg::mode_t                    mode;
		logic [pll_pkg::POS_W-1:0]         position;
		logic signed [pll_pkg::DATA_W-1:0] value;
	} list_op_t;

	typedef struct {
		pll_pkg::status_t                  status;
		logic signed [pll_pkg::DATA_W-1:0] removed;
		logic [pll_pkg::COUNT_W-1:0]       count;
	} list_reply_t;

	logic clk;
	logic arst_n;

	pll_req_if req_ch ();
	pll_rsp_if rsp_ch ();

	positional_linked_list #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// shadow of the slot table
	logic [3:0]                        slot_next [LIST_CAP];
	logic signed [pll_pkg::DATA_W-1:0] slot_word [LIST_CAP];
	logic [3:0]                        head_slot;
	logic [3:0]                        free_slot;
	logic [3:0]                        list_len;

	list_op_t    pending_ops [$];
	list_reply_t awaited_replies [$];
	list_op_t    offered_op;

	int failures = 0;
	int gen_len;
	int req_idle_pct;
	int rsp_idle_pct;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;

	function automatic void list_clear();
		for (int i = 0; i < LIST_CAP; i++) begin
			slot_next[SLOT_W'(i)] = (i + 1 < LIST_CAP) ? 4'(i + 1) : 4'(NULL_SLOT);
			slot_word[SLOT_W'(i)] = '0;
		end
		head_slot = 4'(NULL_SLOT);
		free_slot = 4'd0;
		list_len  = 4'd0;
	endfunction

	// successor of a node; the null slot stands for the list head
	function automatic logic [3:0] follow(logic [3:0] node);
		logic [3:0] n;
		if (node == NULL_SLOT)
			n = head_slot;
		else if (node < LIST_CAP)
			n = slot_next[node[SLOT_W-1:0]];
		else
			n = 4'(NULL_SLOT);
		return (n < LIST_CAP) ? n : 4'(NULL_SLOT);
	endfunction

	function automatic void relink(logic [3:0] node, logic [3:0] target);
		if (node == NULL_SLOT)
			head_slot = target;
		else if (node < LIST_CAP)
			slot_next[node[SLOT_W-1:0]] = target;
	endfunction

	function automatic logic [3:0] seek(logic [3:0] pos);
		logic [3:0] prev;
		logic [3:0] n;
		prev = 4'(NULL_SLOT);
		for (int i = 0; i < pos && i < LIST_CAP; i++) begin
			n = follow(prev);
			if (n == NULL_SLOT)
				break;
			prev = n;
		end
		return prev;
	endfunction

	function automatic list_reply_t list_apply(list_op_t op);
		list_reply_t r;
		logic [3:0]  slot;
		logic [3:0]  prev;
		logic [3:0]  fn;
		r.status  = pll_pkg::STATUS_OK;
		r.removed = '0;
		if (op.mode == pll_pkg::MODE_INSERT) begin
			if (free_slot >= LIST_CAP || list_len >= LIST_CAP) begin
				r.status = pll_pkg::STATUS_FULL;
			end else if (op.position > list_len) begin
				r.status = pll_pkg::STATUS_BAD_POS;
			end else begin
				slot = free_slot;
				prev = seek(op.position);
				fn = slot_next[slot[SLOT_W-1:0]];
				free_slot = (fn < LIST_CAP) ? fn : 4'(NULL_SLOT);
				slot_word[slot[SLOT_W-1:0]] = op.value;
				slot_next[slot[SLOT_W-1:0]] = follow(prev);
				relink(prev, slot);
				list_len++;
			end
		end else begin
			if (op.position >= list_len) begin
				r.status = pll_pkg::STATUS_BAD_POS;
			end else begin
				prev = seek(op.position);
				slot = follow(prev);
				if (slot == NULL_SLOT) begin
					r.status = pll_pkg::STATUS_BAD_POS;
				end else begin
					r.removed = slot_word[slot[SLOT_W-1:0]];
					relink(prev, follow(slot));
					slot_next[slot[SLOT_W-1:0]] = free_slot;
					free_slot = slot;
					list_len--;
				end
			end
		end
		r.count = list_len;
		return r;
	endfunction

	// queue one item and track the list length it leaves behind
	task automatic queue_op(pll_pkg::mode_t m, int p, logic signed [pll_pkg::DATA_W-1:0] v);
		list_op_t op;
		op.mode = m;
		op.position = pll_pkg::POS_W'(p);
		op.value = v;
		pending_ops.push_back(op);
		if (m == pll_pkg::MODE_INSERT && gen_len < LIST_CAP && p <= gen_len)
			gen_len++;
		else if (m == pll_pkg::MODE_DELETE && p < gen_len)
			gen_len--;
	endtask

	task automatic queue_random(int n);
		int             ins_pct;
		pll_pkg::mode_t m;
		int             p;
		repeat (n) begin
			ins_pct = (gen_len < 3) ? 70 : ((gen_len > 6) ? 40 : 55);
			m = ($urandom_range(99) < ins_pct) ? pll_pkg::MODE_INSERT : pll_pkg::MODE_DELETE;
			if ($urandom_range(99) < 12) begin
				// noise: any position, any mode
				m = pll_pkg::mode_t'($urandom_range(1));
				p = $urandom_range(15);
			end else if (m == pll_pkg::MODE_INSERT) begin
				p = $urandom_range(gen_len);
			end else begin
				p = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1);
			end
			queue_op(m, p, $urandom);
		end
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || req_ch.valid || awaited_replies.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			list_clear();
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				awaited_replies.push_back(list_apply(offered_op));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
					offered_op = pending_ops.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.mode <= offered_op.mode;
					req_ch.position <= offered_op.position;
					req_ch.value <= offered_op.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted down in cycles
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			hold_left <= HOLD_LEN;
			holds_served <= holds_served + 1;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		list_reply_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_replies.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: status %0d removed %0d count %0d",
						rsp_ch.status, rsp_ch.removed_value, rsp_ch.item_count);
			end else begin
				want = awaited_replies.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.removed_value !== want.removed ||
						rsp_ch.item_count !== want.count) begin
					failures++;
					if (failures <= 10)
						$display({"mismatch: expected status %0d removed %0d count %0d,",
							" got %0d %0d %0d"},
							want.status, want.removed, want.count,
							rsp_ch.status, rsp_ch.removed_value, rsp_ch.item_count);
				end
			end
		end
		rsp_ch.ready <= arst_n && hold_left == 0 && $urandom_range(99) >= rsp_idle_pct;
	end

	initial begin
		gen_len = 0;
		req_idle_pct = 20;
		rsp_idle_pct = 64;

		// empty list, bad positions
		queue_op(pll_pkg::MODE_DELETE, 0, 32'sd5);
		queue_op(pll_pkg::MODE_DELETE, 15, 32'sd0);
		queue_op(pll_pkg::MODE_INSERT, 1, 32'sd9);
		// fill at head, tail and middle
		queue_op(pll_pkg::MODE_INSERT, 0, 32'sh7fffffff);
		queue_op(pll_pkg::MODE_INSERT, 1, 32'sh80000000);
		queue_op(pll_pkg::MODE_INSERT, 0, -32'sd1);
		queue_op(pll_pkg::MODE_INSERT, 2, 32'sd0);
		queue_op(pll_pkg::MODE_INSERT, 5, 32'sd17);
		queue_op(pll_pkg::MODE_INSERT, 4, 32'sh55555555);
		queue_op(pll_pkg::MODE_INSERT, 2, 32'shaaaaaaaa);
		queue_op(pll_pkg::MODE_INSERT, 6, 32'sh12345678);
		queue_op(pll_pkg::MODE_INSERT, 3, 32'sh0f0f0f0f);
		// full table wins over a bad position
		queue_op(pll_pkg::MODE_INSERT, 15, 32'sd1);
		queue_op(pll_pkg::MODE_INSERT, 0, 32'sd2);
		queue_op(pll_pkg::MODE_DELETE, 8, 32'sd0);
		queue_op(pll_pkg::MODE_DELETE, 15, 32'sd0);
		queue_op(pll_pkg::MODE_DELETE, 7, 32'sd0);
		queue_op(pll_pkg::MODE_DELETE, 0, 32'sd0);
		queue_op(pll_pkg::MODE_DELETE, 3, 32'sd0);
		// reuse a freed slot
		queue_op(pll_pkg::MODE_INSERT, 1, 32'shf0f0f0f0);
		queue_op(pll_pkg::MODE_DELETE, 5, 32'sd0);
		repeat (5)
			queue_op(pll_pkg::MODE_DELETE, 0, 32'sd0);
		queue_op(pll_pkg::MODE_DELETE, 0, 32'sd0);

		queue_random(30);
		@(negedge clk);
		holds_asked++;
		queue_random(120);
		drain();

		@(negedge clk);
		req_idle_pct = 64;
		rsp_idle_pct = 20;
		queue_random(150);
		drain();

		@(negedge clk);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		queue_random(40);
		holds_asked++;
		queue_random(85);
		drain();

		repeat (60) @(negedge clk);
		if (failures == 0 && awaited_replies.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
sv/pll_pkg.sv
sv/pll_req_if.sv
sv/pll_rsp_if.sv
sv/pll_link_mem.sv
sv/pll_value_mem.sv
sv/positional_linked_list.sv
sim/tb_positional_linked_list.sv
